// ===== rtl/isosel_pkg.sv =====
// Shared types and constants for the ISO14443A card selection responder.
// No dependencies; imported by isosel_check, the top level and the testbench.
package isosel_pkg;

    localparam int unsigned KEEP_MAX  = 7;  // frame bytes stored per frame
    localparam int unsigned RESP_MAX  = 5;  // longest response frame
    localparam int unsigned CNT_W     = 5;  // received byte counter, wraps
    localparam int unsigned KEPT_W    = 3;
    localparam int unsigned LEN_W     = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;

    typedef logic [KEEP_MAX-1:0][7:0] t_frame;
    typedef logic [RESP_MAX-1:0][7:0] t_resp;

    typedef enum logic [1:0] {
        ST_WAIT_REQA     = 2'd0,
        ST_WAIT_ANTICOLL = 2'd1,
        ST_WAIT_SELECT   = 2'd2,
        ST_WAIT_CMD      = 2'd3
    } t_proto_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CARD_UID = 2'd0,
        CFG_ATQA     = 2'd1,
        CFG_SAK      = 2'd2,
        CFG_UNUSED   = 2'd3
    } t_cfg_index;

    // Protocol bytes.
    localparam logic [7:0] CMD_REQA      = 8'h26;
    localparam logic [7:0] CMD_SEL_CL1   = 8'h93;
    localparam logic [7:0] NVB_ANTICOLL  = 8'h20;
    localparam logic [7:0] NVB_SELECT    = 8'h70;
    localparam logic [7:0] CMD_HALT      = 8'h50;
    localparam logic [7:0] CMD_HALT_ARG  = 8'h00;

    // Transceiver interrupt status codes.
    localparam logic [7:0] IRQ_RX_DONE   = 8'h40;
    localparam logic [7:0] IRQ_TX_DONE   = 8'h80;

    // Register reset values.
    localparam logic [31:0] UID_RESET    = 32'hCD815F76;
    localparam logic [15:0] ATQA_RESET   = 16'h0400;
    localparam logic [7:0]  SAK_RESET    = 8'h08;

    // Outcome of checking one received frame.
    typedef struct packed {
        logic              ok;
        t_proto_state      next_state;
        logic [LEN_W-1:0]  len;
        logic              with_crc;
    } t_check_res;

endpackage

// ===== rtl/iso14443a_card_select_responder_unit.sv =====
// Top level of the ISO14443A card selection responder: input register,
// byte collection, protocol state and response serializer.
// Depends on isosel_pkg and isosel_check.
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+------------------------------------------
//  input    | in        | i_valid / o_stall         | i_command, i_rx_byte, i_irq_status
//  result   | out       | o_valid / i_stall         | o_kind, o_tx_byte, o_with_crc,
//           |           |                           | o_response_length, o_last
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// An accepted beat lands in an input register and is processed from there, so
// a new input beat can be taken every cycle unless a status event waits there.
// A status event that produces a response loads a five-byte response register,
// which sends one result beat per cycle while i_stall is low; such an event
// waits in the input register until the cycle that takes the last beat of an
// earlier response. Received bytes and transmit-done events never wait on output.
// Reset (synchronous, active low) returns the protocol to waiting for REQA,
// clears both byte counts, empties both registers and restores the defaults
// of the configuration registers. The stored frame bytes are not reset.
module iso14443a_card_select_responder_unit
    import isosel_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_command,
    input  logic [7:0]            i_rx_byte,
    input  logic [7:0]            i_irq_status,

    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_kind,
    output logic [7:0]            o_tx_byte,
    output logic                  o_with_crc,
    output logic [LEN_W-1:0]      o_response_length,
    output logic                  o_last,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data
);

    // Configuration registers. The port is always ready; writes to an index
    // beyond the register list are accepted and dropped.
    logic [31:0] r_card_uid;
    logic [15:0] r_atqa;
    logic [7:0]  r_sak;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card_uid <= UID_RESET;
            r_atqa     <= ATQA_RESET;
            r_sak      <= SAK_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CARD_UID: r_card_uid <= i_cfg_data[31:0];
                CFG_ATQA:     r_atqa     <= i_cfg_data[15:0];
                CFG_SAK:      r_sak      <= i_cfg_data[7:0];
                CFG_UNUSED:   ;
                default:      ;
            endcase
        end
    end

    // Input register.
    logic       r_in_valid;
    logic       r_in_command;
    logic [7:0] r_in_rx_byte;
    logic [7:0] r_in_irq;

    // Response register: bytes shift toward index zero as beats leave.
    logic             r_frm_valid;
    logic             r_frm_kind;
    logic             r_frm_crc;
    logic [LEN_W-1:0] r_frm_len;
    logic [LEN_W-1:0] r_frm_left;
    t_resp            r_frm_bytes;

    // Protocol state and frame collection.
    t_proto_state       r_state, n_state;
    logic [CNT_W-1:0]   r_byte_count;
    logic [KEPT_W-1:0]  r_kept_count;
    t_frame             r_frame;

    t_check_res w_chk;
    t_resp      w_resp;

    logic w_is_byte, w_rx_done, w_tx_done, w_needs_out;
    logic w_out_beat, w_frm_free, w_consume, w_load;

    isosel_check u_check (
        .i_state      (r_state),
        .i_byte_count (r_byte_count),
        .i_frame      (r_frame),
        .i_card_uid   (r_card_uid),
        .i_atqa       (r_atqa),
        .i_sak        (r_sak),
        .o_res        (w_chk),
        .o_resp       (w_resp)
    );

    assign w_is_byte   = !r_in_command;
    assign w_rx_done   = r_in_command && (r_in_irq == IRQ_RX_DONE);
    assign w_tx_done   = r_in_command && (r_in_irq == IRQ_TX_DONE);
    // Every status event except transmit done produces at least one beat.
    assign w_needs_out = r_in_command && !w_tx_done;

    assign w_out_beat  = r_frm_valid && !i_stall;
    assign w_frm_free  = !r_frm_valid || (w_out_beat && r_frm_left == LEN_W'(1));
    assign w_consume   = r_in_valid && (!w_needs_out || w_frm_free);
    assign w_load      = w_consume && w_needs_out;

    assign o_stall     = r_in_valid && !w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_command <= i_command;
            r_in_rx_byte <= i_rx_byte;
            r_in_irq     <= i_irq_status;
        end
    end

    // Next protocol state. Any status event but a good frame or transmit done
    // returns to waiting for REQA.
    always_comb begin
        n_state = r_state;
        if (w_consume && r_in_command) begin
            priority if (w_tx_done) begin
                n_state = r_state;
            end else if (w_rx_done && w_chk.ok) begin
                n_state = w_chk.next_state;
            end else begin
                n_state = ST_WAIT_REQA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WAIT_REQA;
        end else begin
            r_state <= n_state;
        end
    end

    // Byte collection: the count wraps, only the first bytes are stored, and
    // any status event discards the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_kept_count <= '0;
        end else if (w_consume) begin
            if (w_is_byte) begin
                r_byte_count <= r_byte_count + CNT_W'(1);
                if (r_kept_count < KEPT_W'(KEEP_MAX)) begin
                    r_kept_count <= r_kept_count + KEPT_W'(1);
                end
            end else begin
                r_byte_count <= '0;
                r_kept_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && w_is_byte && r_kept_count < KEPT_W'(KEEP_MAX)) begin
            r_frame[r_kept_count] <= r_in_rx_byte;
        end
    end

    // Response register. A reinitialize request is a single beat with
    // length zero; a response frame sends its bytes in order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frm_valid <= 1'b0;
            r_frm_left  <= '0;
        end else if (w_load) begin
            r_frm_valid <= 1'b1;
            if (w_rx_done && w_chk.ok) begin
                r_frm_left <= w_chk.len;
            end else begin
                r_frm_left <= LEN_W'(1);
            end
        end else if (w_out_beat) begin
            r_frm_left <= r_frm_left - LEN_W'(1);
            if (r_frm_left == LEN_W'(1)) begin
                r_frm_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_rx_done && w_chk.ok) begin
                r_frm_kind  <= 1'b0;
                r_frm_crc   <= w_chk.with_crc;
                r_frm_len   <= w_chk.len;
                r_frm_bytes <= w_resp;
            end else begin
                r_frm_kind  <= 1'b1;
                r_frm_crc   <= 1'b0;
                r_frm_len   <= '0;
                r_frm_bytes <= '0;
            end
        end else if (w_out_beat) begin
            r_frm_bytes <= t_resp'({8'h00, r_frm_bytes[RESP_MAX-1:1]});
        end
    end

    assign o_valid           = r_frm_valid;
    assign o_kind            = r_frm_kind;
    assign o_tx_byte         = r_frm_bytes[0];
    assign o_with_crc        = r_frm_crc;
    assign o_response_length = r_frm_len;
    assign o_last            = (r_frm_left == LEN_W'(1));

    // A reinitialize request is always a single, final beat.
    a_reinit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> (o_last && o_response_length == '0))
        else $error("reinitialize beat not marked last");

    // Data beats carry a frame length between one and five bytes.
    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_kind) |->
        (o_response_length != '0 && o_response_length <= LEN_W'(RESP_MAX) &&
         r_frm_left <= o_response_length))
        else $error("bad response length on data beat");

    // Until the store fills, stored and counted bytes agree.
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kept_count < KEPT_W'(KEEP_MAX)) |->
        (r_byte_count == CNT_W'(r_kept_count)))
        else $error("byte count and stored count disagree");

    // With the response register empty, the input side never stalls.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_frm_valid |-> !o_stall)
        else $error("input stalled with empty response register");

endmodule

// ===== rtl/isosel_check.sv =====
// Frame checker: compares a collected frame with the protocol state and
// builds the response bytes. Depends on isosel_pkg.
module isosel_check
    import isosel_pkg::*;
(
    input  t_proto_state         i_state,
    input  logic [CNT_W-1:0]     i_byte_count,
    input  t_frame               i_frame,
    input  logic [31:0]          i_card_uid,
    input  logic [15:0]          i_atqa,
    input  logic [7:0]           i_sak,
    output t_check_res           o_res,
    output t_resp                o_resp
);

    logic [7:0] w_uid_b0, w_uid_b1, w_uid_b2, w_uid_b3, w_bcc;
    logic       w_uid_match;

    assign w_uid_b0 = i_card_uid[31:24];
    assign w_uid_b1 = i_card_uid[23:16];
    assign w_uid_b2 = i_card_uid[15:8];
    assign w_uid_b3 = i_card_uid[7:0];
    assign w_bcc    = w_uid_b0 ^ w_uid_b1 ^ w_uid_b2 ^ w_uid_b3;

    assign w_uid_match = (i_frame[2] == w_uid_b0) && (i_frame[3] == w_uid_b1) &&
                         (i_frame[4] == w_uid_b2) && (i_frame[5] == w_uid_b3) &&
                         (i_frame[6] == w_bcc);

    always_comb begin
        o_res.ok         = 1'b0;
        o_res.next_state = ST_WAIT_REQA;
        o_res.len        = '0;
        o_res.with_crc   = 1'b0;
        o_resp           = '0;
        unique case (i_state)
            ST_WAIT_REQA: begin
                if (i_byte_count == CNT_W'(1) && i_frame[0] == CMD_REQA) begin
                    o_res.ok         = 1'b1;
                    o_res.next_state = ST_WAIT_ANTICOLL;
                    o_res.len        = LEN_W'(2);
                    o_resp[0]        = i_atqa[15:8];
                    o_resp[1]        = i_atqa[7:0];
                end
            end
            ST_WAIT_ANTICOLL: begin
                if (i_byte_count == CNT_W'(2) && i_frame[0] == CMD_SEL_CL1 &&
                    i_frame[1] == NVB_ANTICOLL) begin
                    o_res.ok         = 1'b1;
                    o_res.next_state = ST_WAIT_SELECT;
                    o_res.len        = LEN_W'(5);
                    o_resp[0]        = w_uid_b0;
                    o_resp[1]        = w_uid_b1;
                    o_resp[2]        = w_uid_b2;
                    o_resp[3]        = w_uid_b3;
                    o_resp[4]        = w_bcc;
                end
            end
            ST_WAIT_SELECT: begin
                if (i_byte_count >= CNT_W'(9) && i_frame[0] == CMD_SEL_CL1 &&
                    i_frame[1] == NVB_SELECT && w_uid_match) begin
                    o_res.ok         = 1'b1;
                    o_res.next_state = ST_WAIT_CMD;
                    o_res.len        = LEN_W'(1);
                    o_res.with_crc   = 1'b1;
                    o_resp[0]        = i_sak;
                end
            end
            ST_WAIT_CMD: begin
                // HALT is treated as an error and drops back to idle.
                if (i_byte_count > CNT_W'(2) &&
                    !(i_frame[0] == CMD_HALT && i_frame[1] == CMD_HALT_ARG)) begin
                    o_res.ok         = 1'b1;
                    o_res.next_state = ST_WAIT_REQA;
                    o_res.len        = LEN_W'(4);
                    o_res.with_crc   = 1'b1;
                end
            end
            default: begin
                o_res.ok = 1'b0;
            end
        endcase
    end

endmodule

// ===== tb/tb_iso14443a_card_select_responder_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the ISO14443A card selection responder.
// Depends on isosel_pkg and the iso14443a_card_select_responder_unit RTL only.

module tb_iso14443a_card_select_responder_unit;
    import isosel_pkg::*;

    // The watchdog ends the run after this many cycles without any handshake.
    // The longest legitimate quiet stretch is the output hold-off below, so the
    // limit sits well above it.
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 8;

    // One expected result beat, field by field as the block presents it.
    typedef struct packed {
        logic             kind;
        logic [7:0]       tx_byte;
        logic             with_crc;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_resp_beat;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic                 o_stall;
    logic                 i_command    = 1'b0;
    logic [7:0]           i_rx_byte    = 8'h00;
    logic [7:0]           i_irq_status = 8'h00;
    logic                 o_valid;
    logic                 i_stall      = 1'b0;
    logic                 o_kind;
    logic [7:0]           o_tx_byte;
    logic                 o_with_crc;
    logic [LEN_W-1:0]     o_response_length;
    logic                 o_last;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = CFG_CARD_UID;
    logic [CFG_DAT_W-1:0] i_cfg_data   = '0;

    // Predicted card state and the testbench's copy of the configuration.
    t_proto_state proto_q   = ST_WAIT_REQA;
    logic [CNT_W-1:0]  rx_count = '0;
    logic [KEPT_W-1:0] kept_q   = '0;
    logic [7:0]   frame_q [KEEP_MAX];
    logic [31:0]  uid_q     = UID_RESET;
    logic [15:0]  atqa_q    = ATQA_RESET;
    logic [7:0]   sak_q     = SAK_RESET;

    // Response beats still owed by the block, oldest first.
    t_resp_beat   tx_expected [$];
    t_resp_beat   tx_head;

    // Bytes of the next frame that the stimulus will send.
    logic [7:0]   frame_out [$];

    int src_idle_pct  = 16;
    int sink_idle_pct = 65;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;
    int mismatches    = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int cfg_writes    = 0;

    iso14443a_card_select_responder_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command         (i_command),
        .i_rx_byte         (i_rx_byte),
        .i_irq_status      (i_irq_status),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_kind            (o_kind),
        .o_tx_byte         (o_tx_byte),
        .o_with_crc        (o_with_crc),
        .o_response_length (o_response_length),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [7:0] any_octet();
        return 8'($urandom_range(255));
    endfunction

    // UID bytes go out most significant first, so byte 0 is the top byte.
    function automatic logic [7:0] uid_byte(int i);
        return uid_q[31 - 8 * i -: 8];
    endfunction

    // Advances the predicted card by one accepted input beat and queues the
    // response beats that beat must produce. Received bytes only fill the frame;
    // a status event judges the frame against the protocol state.
    function automatic void card_answer(logic cmd, logic [7:0] rx, logic [7:0] irq);
        t_resp      resp_bytes;
        int         n_resp;
        logic       crc_on;
        logic       refused;
        logic       uid_ok;
        logic [7:0] bcc;
        t_resp_beat beat_v;
        resp_bytes = '0;
        n_resp     = 0;
        crc_on     = 1'b0;
        refused    = 1'b0;
        uid_ok     = 1'b1;
        bcc        = '0;
        if (!cmd) begin
            // Only the first seven bytes are stored, but every byte is counted
            // and the count wraps at 32.
            if (kept_q < KEEP_MAX) begin
                frame_q[kept_q] = rx;
                kept_q = kept_q + 1'b1;
            end
            rx_count = rx_count + 1'b1;
            return;
        end
        if (irq == IRQ_RX_DONE) begin
            case (proto_q)
                ST_WAIT_REQA: begin
                    if (rx_count == 1 && frame_q[0] == CMD_REQA) begin
                        resp_bytes[0] = atqa_q[15:8];
                        resp_bytes[1] = atqa_q[7:0];
                        n_resp  = 2;
                        proto_q = ST_WAIT_ANTICOLL;
                    end else begin
                        refused = 1'b1;
                    end
                end
                ST_WAIT_ANTICOLL: begin
                    if (rx_count == 2 && frame_q[0] == CMD_SEL_CL1
                            && frame_q[1] == NVB_ANTICOLL) begin
                        for (int i = 0; i < 4; i++) begin
                            resp_bytes[i] = uid_byte(i);
                            resp_bytes[4] ^= uid_byte(i);
                        end
                        n_resp  = 5;
                        proto_q = ST_WAIT_SELECT;
                    end else begin
                        refused = 1'b1;
                    end
                end
                ST_WAIT_SELECT: begin
                    if (rx_count >= 9 && frame_q[0] == CMD_SEL_CL1
                            && frame_q[1] == NVB_SELECT) begin
                        for (int i = 0; i < 4; i++) begin
                            bcc ^= uid_byte(i);
                            if (frame_q[2 + i] != uid_byte(i)) uid_ok = 1'b0;
                        end
                        if (frame_q[6] != bcc) uid_ok = 1'b0;
                    end else begin
                        uid_ok = 1'b0;
                    end
                    if (uid_ok) begin
                        resp_bytes[0] = sak_q;
                        n_resp  = 1;
                        crc_on  = 1'b1;
                        proto_q = ST_WAIT_CMD;
                    end else begin
                        refused = 1'b1;
                    end
                end
                default: begin
                    if (rx_count > 2 && !(frame_q[0] == CMD_HALT
                            && frame_q[1] == CMD_HALT_ARG)) begin
                        n_resp  = 4;
                        crc_on  = 1'b1;
                        proto_q = ST_WAIT_REQA;
                    end else begin
                        refused = 1'b1;
                    end
                end
            endcase
        end else if (irq != IRQ_TX_DONE) begin
            refused = 1'b1;
        end
        if (refused) begin
            proto_q         = ST_WAIT_REQA;
            beat_v.kind     = 1'b1;
            beat_v.tx_byte  = 8'h00;
            beat_v.with_crc = 1'b0;
            beat_v.len      = '0;
            beat_v.last     = 1'b1;
            tx_expected.push_back(beat_v);
        end else begin
            for (int i = 0; i < n_resp; i++) begin
                beat_v.kind     = 1'b0;
                beat_v.tx_byte  = resp_bytes[i];
                beat_v.with_crc = crc_on;
                beat_v.len      = n_resp[LEN_W-1:0];
                beat_v.last     = (i == n_resp - 1);
                tx_expected.push_back(beat_v);
            end
        end
        rx_count = '0;
        kept_q   = '0;
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Offers one input beat, with a random gap in front of it, and returns at
    // the clock edge where the block takes it. Valid stays high on return, so
    // the next call can follow back to back; settle() lowers it otherwise.
    task automatic send_beat(logic cmd, logic [7:0] rx, logic [7:0] irq);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_rx_byte    <= rx;
        i_irq_status <= irq;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        card_answer(cmd, rx, irq);
        items_sent++;
    endtask

    // Sends the bytes in frame_out followed by one status event.
    task automatic send_frame(logic [7:0] status);
        foreach (frame_out[i]) send_beat(1'b0, frame_out[i], any_octet());
        send_beat(1'b1, any_octet(), status);
    endtask

    // Stops offering beats and waits until every owed response beat has come
    // out, then lets a drain stretch pass for beats that produce nothing.
    task automatic settle();
        i_valid <= 1'b0;
        while (tx_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_index idx, logic [31:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_CARD_UID: uid_q  = value;
            CFG_ATQA:     atqa_q = value[15:0];
            CFG_SAK:      sak_q  = value[7:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic apply_settings(logic [31:0] uid_v, logic [31:0] atqa_v, logic [31:0] sak_v);
        write_register(CFG_CARD_UID, uid_v);
        write_register(CFG_ATQA, atqa_v);
        write_register(CFG_SAK, sak_v);
    endtask

    // Builds the frame that the reader would send next in the predicted state.
    // Unless plain is set, some frames carry extra bytes or are long enough to
    // wrap the byte count back to the value the check wants.
    task automatic build_good_frame(bit plain);
        logic [7:0] bcc;
        bcc = '0;
        frame_out.delete();
        case (proto_q)
            ST_WAIT_REQA: begin
                frame_out.push_back(CMD_REQA);
                if (!plain && $urandom_range(15) == 0)
                    repeat (32) frame_out.push_back(any_octet());
            end
            ST_WAIT_ANTICOLL: begin
                frame_out.push_back(CMD_SEL_CL1);
                frame_out.push_back(NVB_ANTICOLL);
            end
            ST_WAIT_SELECT: begin
                frame_out.push_back(CMD_SEL_CL1);
                frame_out.push_back(NVB_SELECT);
                for (int i = 0; i < 4; i++) begin
                    frame_out.push_back(uid_byte(i));
                    bcc ^= uid_byte(i);
                end
                frame_out.push_back(bcc);
                frame_out.push_back(any_octet());
                frame_out.push_back(any_octet());
                if (!plain) begin
                    if ($urandom_range(15) == 0)
                        repeat (32) frame_out.push_back(any_octet());
                    else if ($urandom_range(3) == 0)
                        repeat ($urandom_range(1, 22)) frame_out.push_back(any_octet());
                end
            end
            default: begin
                repeat ($urandom_range(3, 8)) frame_out.push_back(any_octet());
                if (frame_out[0] == CMD_HALT && frame_out[1] == CMD_HALT_ARG)
                    frame_out[1] = ~CMD_HALT_ARG;
            end
        endcase
    endtask

    // Breaks the frame in frame_out: a flipped bit, a byte too few or too
    // many, random junk, or 32 junk bytes that wrap the count to zero.
    task automatic corrupt_frame();
        int pos;
        case ($urandom_range(4))
            0: begin
                if (frame_out.size() != 0) begin
                    pos = $urandom_range(frame_out.size() > 7 ? 6 : frame_out.size() - 1);
                    frame_out[pos] = frame_out[pos] ^ (8'h01 << $urandom_range(7));
                end
            end
            1: if (frame_out.size() != 0) void'(frame_out.pop_back());
            2: frame_out.push_back(any_octet());
            3: begin
                frame_out.delete();
                repeat ($urandom_range(10)) frame_out.push_back(any_octet());
            end
            default: begin
                frame_out.delete();
                repeat (32) frame_out.push_back(any_octet());
            end
        endcase
    endtask

    // One reader exchange: an optional transmit-done event, then a frame that
    // is mostly the right one for the current state, closed by a status event.
    task automatic random_exchange();
        int         roll;
        logic [7:0] status;
        if ($urandom_range(99) < 12) send_beat(1'b1, any_octet(), IRQ_TX_DONE);
        build_good_frame(1'b0);
        roll = $urandom_range(99);
        if (proto_q == ST_WAIT_CMD && roll < 20) begin
            frame_out.delete();
            frame_out.push_back(CMD_HALT);
            frame_out.push_back(CMD_HALT_ARG);
            frame_out.push_back(any_octet());
            frame_out.push_back(any_octet());
        end else if (roll >= 78) begin
            corrupt_frame();
        end
        roll = $urandom_range(99);
        if (roll < 86) begin
            status = IRQ_RX_DONE;
        end else if (roll < 91) begin
            status = IRQ_TX_DONE;
        end else begin
            do status = any_octet(); while (status == IRQ_RX_DONE || status == IRQ_TX_DONE);
        end
        send_frame(status);
    endtask

    // A complete selection with the reset settings, ending in a command frame
    // built from extreme byte values.
    task automatic test_selection_defaults();
        repeat (3) begin
            build_good_frame(1'b1);
            send_frame(IRQ_RX_DONE);
        end
        frame_out.delete();
        frame_out.push_back(8'hFF);
        frame_out.push_back(8'h00);
        frame_out.push_back(8'hFF);
        send_frame(IRQ_RX_DONE);
    endtask

    // Status events outside the happy path: a transmit-done with no effect,
    // unknown status codes at both extremes, an empty frame and a wrong byte.
    task automatic test_status_events();
        frame_out.delete();
        send_frame(IRQ_TX_DONE);
        send_frame(8'h00);
        send_frame(8'hFF);
        send_frame(IRQ_RX_DONE);
        frame_out.push_back(8'h52);
        send_frame(IRQ_RX_DONE);
    endtask

    task automatic test_random_traffic(int n_items, int src_pct, int sink_pct);
        int stop_at;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) random_exchange();
        settle();
    endtask

    // The receiver holds off for a long stretch while the sender keeps going,
    // so response beats pile up and the block has to stall its input.
    task automatic test_output_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_requests++;
        repeat (8) begin
            build_good_frame(1'b1);
            send_frame(IRQ_RX_DONE);
        end
        settle();
    endtask

    // Receiver side. A pending hold-off request stalls the output until the
    // hold_left count, loaded from HOLD_CYCLES, runs down; otherwise the stall is random.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    // Every result beat taken by the receiver is compared with the oldest
    // expected beat. A beat with nothing owed is a failure of its own.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            results_seen++;
            if (tx_expected.size() == 0) begin
                $error("unexpected result beat: kind %0h tx_byte %0h", o_kind, o_tx_byte);
                mismatches++;
            end else begin
                tx_head = tx_expected.pop_front();
                check_field("kind", 8'(tx_head.kind), 8'(o_kind));
                check_field("tx_byte", tx_head.tx_byte, o_tx_byte);
                check_field("with_crc", 8'(tx_head.with_crc), 8'(o_with_crc));
                check_field("response_length", 8'(tx_head.len), 8'(o_response_length));
                check_field("last", 8'(tx_head.last), 8'(o_last));
            end
        end
    end

    // Watchdog: any handshake on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d beats still owed",
                     idle_cycles, tx_expected.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // The stored frame starts cleared in the prediction; the checks never
        // read a byte that the current frame did not write.
        foreach (frame_q[i]) frame_q[i] = 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_selection_defaults();
        test_status_events();

        // All-ones data, so the unused upper bits of the narrow registers are
        // driven high too.
        apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        test_random_traffic(140, 16, 65);

        // All zeros, plus a write to the unused index that must change nothing.
        apply_settings(32'h0, 32'h0, 32'h0);
        write_register(CFG_UNUSED, $urandom());
        test_random_traffic(140, 65, 16);

        apply_settings($urandom(), $urandom(), $urandom());
        test_random_traffic(140, 0, 0);

        test_output_backpressure();

        $display("Sent %0d input beats, checked %0d result beats, made %0d register writes.",
                 items_sent, results_seen, cfg_writes);
        $display("Covered reset, all-ones, all-zero and random card settings and a long hold-off.");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
